@@ hw/rtl/pgfa_pkg.sv @@
package pgfa_pkg;

  localparam logic signed [15:0] MAX_RESET = -16'sd1280;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [27:0] LN2_Q28 = 28'd186065279;

  typedef struct packed {
    logic signed [15:0] max_h;
    logic [7:0]         top_i;
    logic signed [31:0] hsum;
    logic [23:0]        isum;
    logic [15:0]        cnt;
  } cell_t;

  localparam cell_t CELL_RESET = '{
    max_h: MAX_RESET, top_i: 8'd0, hsum: 32'sd0, isum: 24'd0, cnt: 16'd0
  };

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_MOD, S_DIVH, S_DIVI, S_WAITLOG, S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    LOG_IDLE, LOG_NORM, LOG_SQ, LOG_ACC, LOG_MUL, LOG_SUM
  } log_state_t;

endpackage

@@ hw/rtl/point_grid_feature_accumulator_core.sv @@
// Lidar bird's-eye-view feature grid.
// Input channel (in_valid/in_stall): func 0 folds one point (cell_index,
// height Q8.8, intensity) into its cell; func 1 reads the cell's features
// and clears it. Negative or out-of-grid indexes are ignored; a read of
// one gives an all-zero result.
// Output channel (out_valid/out_stall): one transaction per read request.
// Config channel (cfg_valid/cfg_ready/cfg_data): intensity_enable, always
// ready; write it only while the block is idle.
// Per-cell state sits in one single-port-read, single-port-write RAM.
// An accumulate steps through accept, RAM read and modify-write, and the
// input stalls until it is through. A read of a nonempty cell waits for
// the log unit (30 squaring steps after a normalize search) and for the
// two divides, which run one after the other beside it. Reads of empty or
// invalid cells skip the divides and the log unit.
// After reset the RAM is swept to its reset contents, one cell a cycle,
// min(GRID_SIDE*GRID_SIDE, 65536) cells in all, with in_stall high.
// A finished result waits in the output register while out_stall is high;
// the block takes new items meanwhile and holds a following read result
// until the register frees.
module point_grid_feature_accumulator_core
  import pgfa_pkg::*;
#(
  parameter int GRID_SIDE = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic signed [16:0] cell_index,
  input  logic signed [15:0] height,
  input  logic [7:0]         intensity,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] peak_height,
  output logic signed [15:0] mean_height,
  output logic [7:0]         top_intensity,
  output logic [7:0]         mean_intensity,
  output logic [15:0]        log_count,
  output logic               nonempty,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int DEPTH = (CELLS < 65536) ? CELLS : 65536;
  localparam int AW = $clog2(DEPTH);
  localparam logic [16:0] LIMIT = 17'(DEPTH);

  state_t state, state_next;
  logic            ien;
  logic            func_q;
  logic [AW-1:0]   addr_q;
  logic signed [15:0] h_q;
  logic [7:0]      i_q;
  logic [AW-1:0]   clr_addr;

  cell_t           mem [DEPTH];
  cell_t           rdata;
  cell_t           wr_data;
  logic            wr_en;
  logic            rd_en;
  logic [AW-1:0]   wr_addr;

  logic            acc_in;
  logic            idx_ok;
  logic            out_free;
  logic            div_start;
  logic            div_done;
  logic [31:0]     div_dvd;
  logic [31:0]     div_q;
  logic            log_start;
  logic            log_busy;
  logic [15:0]     log_res;
  logic [31:0]     hmag;
  logic            hneg;
  logic [31:0]     hmean;

  logic signed [15:0] res_max;
  logic signed [15:0] res_mean;
  logic [7:0]      res_top;
  logic [7:0]      res_mi;
  logic            res_ne;

  assign acc_in = in_valid && !in_stall;
  assign idx_ok = !cell_index[16] && ({1'b0, cell_index[15:0]} < LIMIT);
  assign out_free = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;
  assign hneg = rdata.hsum[31];
  assign hmag = hneg ? (~rdata.hsum + 32'd1) : rdata.hsum;
  assign hmean = res_mean[15] ? (~div_q + 32'd1) : div_q;

  pgfa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (rdata.cnt),
    .done     (div_done),
    .quotient (div_q)
  );

  pgfa_log u_log (
    .clk    (clk),
    .rst    (rst),
    .start  (log_start),
    .count  (rdata.cnt),
    .busy   (log_busy),
    .result (log_res)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_addr == AW'(DEPTH - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (acc_in) begin
          if (idx_ok) state_next = S_READ;
          else if (func) state_next = S_EMIT;
        end
      end
      S_READ: state_next = S_MOD;
      S_MOD: begin
        if (!func_q) state_next = S_IDLE;
        else if (rdata.cnt == '0) state_next = S_EMIT;
        else state_next = S_DIVH;
      end
      S_DIVH:    if (div_done) state_next = S_DIVI;
      S_DIVI:    if (div_done) state_next = S_WAITLOG;
      S_WAITLOG: if (!log_busy) state_next = S_EMIT;
      S_EMIT:    if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = state != S_IDLE;
    rd_en = state == S_READ;
    wr_en = 1'b0;
    wr_addr = addr_q;
    wr_data = CELL_RESET;
    div_start = 1'b0;
    div_dvd = hmag;
    log_start = 1'b0;
    unique case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = clr_addr;
      end
      S_MOD: begin
        wr_en = 1'b1;
        if (!func_q) begin
          wr_data = rdata;
          if (rdata.max_h < h_q) begin
            wr_data.max_h = h_q;
            if (ien) wr_data.top_i = i_q;
          end
          if (rdata.cnt != COUNT_MAX) begin
            wr_data.hsum = rdata.hsum + 32'(h_q);
            if (ien) wr_data.isum = rdata.isum + 24'(i_q);
            wr_data.cnt = rdata.cnt + 16'd1;
          end
        end else if (rdata.cnt != '0) begin
          div_start = 1'b1;
          log_start = 1'b1;
        end
      end
      S_DIVH: begin
        div_start = div_done;
        div_dvd = {8'd0, rdata.isum};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[addr_q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      ien <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (cfg_valid && cfg_ready) ien <= cfg_data;
      if (state == S_EMIT && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      func_q <= func;
      addr_q <= cell_index[AW-1:0];
      h_q <= height;
      i_q <= intensity;
      res_max <= '0;
      res_mean <= '0;
      res_top <= '0;
      res_mi <= '0;
      res_ne <= 1'b0;
    end
    if (state == S_MOD && func_q && rdata.cnt != '0) begin
      res_max <= rdata.max_h;
      res_top <= ien ? rdata.top_i : 8'd0;
      res_ne <= 1'b1;
      res_mean <= {hneg, 15'd0};
    end
    if (state == S_DIVH && div_done) res_mean <= hmean[15:0];
    if (state == S_DIVI && div_done) res_mi <= ien ? div_q[7:0] : 8'd0;
    if (state == S_EMIT && out_free) begin
      peak_height <= res_max;
      mean_height <= res_mean;
      top_intensity <= res_top;
      mean_intensity <= res_mi;
      log_count <= res_ne ? log_res : 16'd0;
      nonempty <= res_ne;
    end
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    acc_in |-> state == S_IDLE)
    else $error("item accepted outside idle");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_MOD || state == S_CLEAR))
    else $error("RAM write outside modify or clear");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !nonempty |-> peak_height == 0 && mean_height == 0 && log_count == 0)
    else $error("empty result carries nonzero features");

  a_log_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && nonempty |-> log_count != 0)
    else $error("nonempty cell with zero log count");

  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> in_stall && !out_valid)
    else $error("input open during clearing pass");

endmodule

@@ hw/rtl/pgfa_div.sv @@
module pgfa_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy;
  logic [4:0]  step;
  logic [31:0] dvd;
  logic [15:0] rem;
  logic [15:0] dsr;
  logic [16:0] trial;
  logic        fits;

  assign trial = {rem, dvd[31]};
  assign fits = trial >= {1'b0, dsr};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? 16'(trial - {1'b0, dsr}) : trial[15:0];
      dvd <= {dvd[30:0], fits};
    end
  end

endmodule

@@ hw/rtl/pgfa_log.sv @@
module pgfa_log
  import pgfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] count,
  output logic        busy,
  output logic [15:0] result
);

  log_state_t state, state_next;
  logic [16:0] xn;
  logic [4:0]  k;
  logic [30:0] m;
  logic [61:0] sq;
  logic [31:0] m2;
  logic [29:0] frac;
  logic [4:0]  iter;
  logic [57:0] p1;
  logic [32:0] kc;
  logic [63:0] total;

  assign m2 = sq[61:30];
  assign total = {1'b0, kc, 30'd0} + {6'd0, p1} + (64'd1 << 45);

  always_comb begin
    state_next = state;
    unique case (state)
      LOG_IDLE: if (start) state_next = LOG_NORM;
      LOG_NORM: if (xn[16]) state_next = LOG_SQ;
      LOG_SQ:   state_next = LOG_ACC;
      LOG_ACC:  state_next = (iter == 5'd29) ? LOG_MUL : LOG_SQ;
      LOG_MUL:  state_next = LOG_SUM;
      LOG_SUM:  state_next = LOG_IDLE;
      default:  state_next = LOG_IDLE;
    endcase
  end

  always_comb begin
    busy = state != LOG_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= LOG_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      LOG_IDLE: begin
        if (start) begin
          xn <= {1'b0, count} + 17'd1;
          k <= 5'd16;
        end
      end
      LOG_NORM: begin
        if (xn[16]) begin
          m <= {xn, 14'd0};
          iter <= '0;
          frac <= '0;
        end else begin
          xn <= {xn[15:0], 1'b0};
          k <= k - 5'd1;
        end
      end
      LOG_SQ: sq <= m * m;
      LOG_ACC: begin
        m <= m2[31] ? m2[31:1] : m2[30:0];
        frac <= {frac[28:0], m2[31]};
        iter <= iter + 5'd1;
      end
      LOG_MUL: begin
        p1 <= 58'(frac) * 58'(LN2_Q28);
        kc <= 33'(k) * 33'(LN2_Q28);
      end
      LOG_SUM: result <= total[61:46];
      default: ;
    endcase
  end

endmodule

@@ test/point_grid_feature_checker.sv @@
`timescale 1ns / 1ps
module point_grid_feature_checker #(
  parameter int GRID_SIDE = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               func,
  input  logic signed [16:0] cell_index,
  input  logic signed [15:0] height,
  input  logic [7:0]         intensity,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] peak_height,
  input  logic signed [15:0] mean_height,
  input  logic [7:0]         top_intensity,
  input  logic [7:0]         mean_intensity,
  input  logic [15:0]        log_count,
  input  logic               nonempty,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_data,
  output int                 fail_count,
  output int                 pending_reads
);
  import pgfa_pkg::*;

  typedef struct packed {
    logic signed [15:0] max_h;
    logic signed [15:0] mean_h;
    logic [7:0]         top_i;
    logic [7:0]         mean_i;
    logic [15:0]        lc;
    logic               ne;
  } features_t;

  cell_t     grid [int];
  logic      int_en;
  features_t feature_q[$];

  assign pending_reads = feature_q.size();

  function automatic logic [15:0] ln_one_plus_q12(logic [15:0] n);
    logic [63:0] x, m, frac, l2;
    logic [127:0] prod;
    int k;
    x = 64'(n) + 1;
    k = 0;
    frac = 0;
    while ((x >> (k + 1)) != 0) k++;
    m = x << (30 - k);
    for (int i = 1; i <= 30; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac |= 64'd1 << (30 - i);
      end
    end
    l2 = (64'(k) << 30) | frac;
    prod = 128'(l2) * 128'(LN2_Q28) + (128'd1 << 45);
    return prod[61:46];
  endfunction

  function automatic cell_t cell_at(int c);
    return grid.exists(c) ? grid[c] : CELL_RESET;
  endfunction

  task automatic apply_item(logic f, logic signed [16:0] idx, logic signed [15:0] h,
                            logic [7:0] it);
    cell_t     cs;
    features_t r;
    int        c;
    logic signed [31:0] q;
    bit ok;
    c = int'(idx);
    ok = idx >= 0 && c < GRID_SIDE * GRID_SIDE;
    cs = cell_at(c);
    if (!f) begin
      if (!ok) return;
      if (cs.max_h < h) begin
        cs.max_h = h;
        if (int_en) cs.top_i = it;
      end
      if (cs.cnt != COUNT_MAX) begin
        cs.hsum = cs.hsum + 32'(h);
        if (int_en) cs.isum = cs.isum + 24'(it);
        cs.cnt++;
      end
      grid[c] = cs;
      return;
    end
    r = '0;
    if (ok && cs.cnt != 0) begin
      q = cs.hsum / $signed({16'd0, cs.cnt});
      r.max_h = cs.max_h;
      r.mean_h = q[15:0];
      if (int_en) begin
        r.top_i = cs.top_i;
        r.mean_i = 8'(cs.isum / 24'(cs.cnt));
      end
      r.lc = ln_one_plus_q12(cs.cnt);
      r.ne = 1'b1;
    end
    if (ok) grid.delete(c);
    feature_q.push_back(r);
  endtask

  always @(posedge clk) begin
    features_t e, a;
    if (rst) begin
      int_en = 1'b1;
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) int_en = cfg_data;
      if (in_valid && !in_stall) apply_item(func, cell_index, height, intensity);
      if (out_valid && !out_stall) begin
        a = '{peak_height, mean_height, top_intensity, mean_intensity, log_count, nonempty};
        if (feature_q.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10) $display("unexpected read transaction: %p", a);
        end else begin
          e = feature_q.pop_front();
          if (a !== e) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10) $display("read mismatch: expected %p actual %p", e, a);
          end
        end
      end
    end
  end
endmodule

@@ test/tb_point_grid_feature_accumulator_core.sv @@
`timescale 1ns / 1ps
module tb_point_grid_feature_accumulator_core;
  localparam int GRID_SIDE = 256;
  localparam int LIMIT = 3000000;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, func = 0;
  logic signed [16:0] cell_index = 0;
  logic signed [15:0] height = 0;
  logic [7:0] intensity = 0;
  logic out_valid, out_stall = 0;
  logic signed [15:0] peak_height, mean_height;
  logic [7:0] top_intensity, mean_intensity;
  logic [15:0] log_count;
  logic nonempty;
  logic cfg_valid = 0, cfg_ready, cfg_data = 0;
  int fail_count, pending_reads, cycles = 0;
  int out_wait = 0;

  always #1 clk = ~clk;

  point_grid_feature_accumulator_core #(.GRID_SIDE(GRID_SIDE)) dut (.*);

  point_grid_feature_checker #(.GRID_SIDE(GRID_SIDE)) checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // each result waits a drawn number of cycles before it is taken
  always @(posedge clk) begin
    int w;
    w = $urandom_range(6);
    if (rst || (out_valid && !out_stall)) begin
      out_wait <= w;
      out_stall <= (w != 0);
    end else if (out_valid) begin
      out_wait <= out_wait - 1;
      out_stall <= (out_wait > 1);
    end
  end

  task automatic send(logic f, logic signed [16:0] idx, logic signed [15:0] h,
                      logic [7:0] it);
    int w;
    w = $urandom_range(6) * int'($urandom_range(4) != 0);
    if (w != 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    cell_index <= idx;
    height <= h;
    intensity <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic set_int_en(logic v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reads != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [16:0] rand_cell(int span);
    int r;
    r = $urandom_range(99);
    if (r < 3) return -17'sd1;
    if (r < 5) return 17'($urandom_range(65535)) | 17'h10000;
    if (r < 8) return 17'($urandom_range(65535));
    return 17'($urandom_range(span - 1));
  endfunction

  initial begin
    logic signed [16:0] c;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    set_int_en(1'b0);
    set_int_en(1'b1);
    // directed: extremes, skip, empty read, low points, full ranges
    send(0, 17'sd0, 16'sh7FFF, 8'hFF);
    send(0, 17'sd0, -16'sh8000, 8'h00);
    send(1, 17'sd0, 0, 0);
    send(0, 17'sd65535, -16'sd1280, 8'h55);
    send(0, 17'sd65535, -16'sd2000, 8'hAA);
    send(1, 17'sd65535, 0, 0);
    send(1, 17'sd65535, 0, 0);
    send(0, -17'sd1, 16'sd100, 8'h11);
    send(1, -17'sd1, 0, 0);
    send(0, 17'h10000, 16'sd5, 8'h7);
    send(1, 17'h1ABCD, 0, 0);
    send(0, 17'sd42, 16'sd256, 8'd10);
    send(0, 17'sd42, 16'sd256, 8'd20);
    send(0, 17'sd42, -16'sd3, 8'd30);
    send(1, 17'sd42, 0, 0);
    for (int p = 0; p < 6; p++) begin
      set_int_en(p[0]);
      for (int i = 0; i < 330; i++) begin
        c = rand_cell((p == 5) ? 65536 : 8);
        if ($urandom_range(5) == 0) send(1, c, 16'($urandom), 8'($urandom));
        else send(0, c, 16'($urandom), 8'($urandom));
      end
      for (int j = 0; j < 8; j++) send(1, 17'(j), 0, 0);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reads != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
